>>> rtl/piecewise_linear_opacity_ramp_defines.svh
// Assertion macros used by the opacity ramp checker.
`ifndef PIECEWISE_LINEAR_OPACITY_RAMP_DEFINES_SVH
`define PIECEWISE_LINEAR_OPACITY_RAMP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define PLOR_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PLOR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/plor_pkg.sv
// Shared widths, codes and types of the opacity ramp.
package plor_pkg;

    localparam int MAX_STOPS_DEF = 16;

    localparam int OP_W   = 2;
    localparam int POS_W  = 17;
    localparam int VAL_W  = 8;
    localparam int X_W    = 8;
    localparam int SEG_W  = 6;
    localparam int ACC_W  = POS_W + VAL_W;
    localparam int NUM_W  = ACC_W + 1;
    localparam int DEN_W  = POS_W + 1;
    localparam int STEP_W = $clog2(VAL_W);
    localparam int FRAC_W = 8;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = OP_W;
    localparam int M_TDATA_W = 16;

    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
    localparam logic [OP_W-1:0] OP_EVAL   = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] val;
    } stop_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [VAL_W-1:0] quot;
    } div_rsp_t;

    typedef struct packed {
        logic [VAL_W-1:0] opacity;
        logic [SEG_W-1:0] segment_index;
        logic             last;
    } res_t;

endpackage

>>> rtl/plor_div.sv
// Restoring divider that retires one quotient bit per cycle.
module plor_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  plor_pkg::div_req_t req,
    output plor_pkg::div_rsp_t rsp
);

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [plor_pkg::STEP_W-1:0]    cnt_reg, cnt_next;
    logic [plor_pkg::NUM_W-1:0]     rem_reg, rem_next;
    logic [plor_pkg::NUM_W-1:0]     dsh_reg, dsh_next;
    logic [plor_pkg::VAL_W-1:0]     q_reg, q_next;
    logic                           ge;
    logic [plor_pkg::NUM_W-1:0]     diff;

    assign ge   = rem_reg >= dsh_reg;
    assign diff = rem_reg - dsh_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        if (req.start) begin
            rem_next  = req.num;
            dsh_next  = plor_pkg::NUM_W'({req.den, {(plor_pkg::VAL_W-1){1'b0}}});
            q_next    = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff : rem_reg;
            dsh_next = dsh_reg >> 1;
            q_next   = {q_reg[plor_pkg::VAL_W-2:0], ge};
            cnt_next = cnt_reg + plor_pkg::STEP_W'(1);
            if (cnt_reg == plor_pkg::STEP_W'(plor_pkg::VAL_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = q_reg;

endmodule

>>> rtl/plor_ctrl.sv
// Stop memory, segment scan and shift-add numerator sequencer.
module plor_ctrl #(
    parameter int MAX_STOPS = plor_pkg::MAX_STOPS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  logic [plor_pkg::OP_W-1:0]  req_op,
    input  logic [plor_pkg::POS_W-1:0] req_pos,
    input  logic [plor_pkg::VAL_W-1:0] req_val,
    input  logic [plor_pkg::X_W-1:0]   req_x,
    output plor_pkg::div_req_t         div_req,
    input  plor_pkg::div_rsp_t         div_rsp,
    output logic                       res_valid,
    input  logic                       res_ready,
    output plor_pkg::res_t             res
);

    localparam int IDX_W = $clog2(MAX_STOPS);
    localparam int CNT_W = $clog2(MAX_STOPS + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_WAIT  = 3'd1;
    localparam logic [2:0] ST_LOAD  = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_DIVGO = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;
    localparam logic [2:0] ST_FLUSH = 3'd7;

    plor_pkg::stop_t stop_mem [MAX_STOPS];
    plor_pkg::stop_t rdata_reg;
    logic            wr_en;

    logic [2:0]                    state_reg, state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic                          pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [plor_pkg::POS_W-1:0]    xf_reg, xf_next;
    plor_pkg::stop_t               prev_reg, prev_next;
    plor_pkg::stop_t               cur_reg, cur_next;
    logic [plor_pkg::POS_W-1:0]    d_reg, d_next;
    logic [plor_pkg::POS_W-1:0]    t_reg, t_next;
    logic [plor_pkg::POS_W-1:0]    dt_reg, dt_next;
    logic [plor_pkg::VAL_W-1:0]    v0_sh_reg, v0_sh_next;
    logic [plor_pkg::VAL_W-1:0]    v1_sh_reg, v1_sh_next;
    logic [plor_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic [plor_pkg::STEP_W-1:0]   bit_reg, bit_next;
    logic [plor_pkg::VAL_W-1:0]    y_reg, y_next;
    logic [plor_pkg::VAL_W-1:0]    pend_y_reg, pend_y_next;
    logic [plor_pkg::SEG_W-1:0]    pend_seg_reg, pend_seg_next;
    logic                          last_seg;
    logic [IDX_W-1:0]              idx_m1;

    assign last_seg = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;
    assign idx_m1   = idx_reg - IDX_W'(1);

    assign req_ready = state_reg == ST_IDLE;

    assign div_req.start = state_reg == ST_DIVGO;
    assign div_req.num   = {acc_reg, 1'b0} + plor_pkg::NUM_W'(d_reg);
    assign div_req.den   = {d_reg, 1'b0};

    assign res.opacity       = pend_y_reg;
    assign res.segment_index = pend_seg_reg;
    assign res.last          = state_reg == ST_FLUSH;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        idx_next        = idx_reg;
        xf_next         = xf_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        d_next          = d_reg;
        t_next          = t_reg;
        dt_next         = dt_reg;
        v0_sh_next      = v0_sh_reg;
        v1_sh_next      = v1_sh_reg;
        acc_next        = acc_reg;
        bit_next        = bit_reg;
        y_next          = y_reg;
        pend_y_next     = pend_y_reg;
        pend_seg_next   = pend_seg_reg;
        wr_en           = 1'b0;
        res_valid       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (req_valid) begin
                    unique case (req_op)
                        plor_pkg::OP_CLEAR: begin
                            count_next = '0;
                        end
                        plor_pkg::OP_APPEND: begin
                            if (count_reg < CNT_W'(MAX_STOPS)) begin
                                wr_en      = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        plor_pkg::OP_EVAL: begin
                            xf_next = plor_pkg::POS_W'({req_x, {plor_pkg::FRAC_W{1'b0}}});
                            if (count_reg >= CNT_W'(2)) begin
                                idx_next   = '0;
                                state_next = ST_WAIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_WAIT: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cur_next = rdata_reg;
                if (idx_reg == '0) begin
                    prev_next  = rdata_reg;
                    idx_next   = IDX_W'(1);
                    state_next = ST_WAIT;
                end else if (prev_reg.pos <= xf_reg && rdata_reg.pos >= xf_reg) begin
                    d_next     = rdata_reg.pos - prev_reg.pos;
                    t_next     = xf_reg - prev_reg.pos;
                    dt_next    = rdata_reg.pos - xf_reg;
                    v0_sh_next = prev_reg.val;
                    v1_sh_next = rdata_reg.val;
                    acc_next   = '0;
                    bit_next   = '0;
                    if (rdata_reg.pos == prev_reg.pos) begin
                        y_next     = prev_reg.val;
                        state_next = ST_EMIT;
                    end else begin
                        state_next = ST_MUL;
                    end
                end else begin
                    prev_next = rdata_reg;
                    if (last_seg) begin
                        state_next = ST_FLUSH;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_MUL: begin
                acc_next = {acc_reg[plor_pkg::ACC_W-2:0], 1'b0}
                         + (v0_sh_reg[plor_pkg::VAL_W-1] ? plor_pkg::ACC_W'(dt_reg) : '0)
                         + (v1_sh_reg[plor_pkg::VAL_W-1] ? plor_pkg::ACC_W'(t_reg) : '0);
                v0_sh_next = {v0_sh_reg[plor_pkg::VAL_W-2:0], 1'b0};
                v1_sh_next = {v1_sh_reg[plor_pkg::VAL_W-2:0], 1'b0};
                bit_next   = bit_reg + plor_pkg::STEP_W'(1);
                if (bit_reg == plor_pkg::STEP_W'(plor_pkg::VAL_W - 1)) begin
                    state_next = ST_DIVGO;
                end
            end
            ST_DIVGO: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_rsp.done) begin
                    y_next     = div_rsp.quot;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!pend_valid_reg || res_ready) begin
                    res_valid       = pend_valid_reg;
                    pend_y_next     = y_reg;
                    pend_seg_next   = plor_pkg::SEG_W'(idx_m1);
                    pend_valid_next = 1'b1;
                    prev_next       = cur_reg;
                    if (last_seg) begin
                        state_next = ST_FLUSH;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_WAIT;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else begin
                    res_valid = 1'b1;
                    if (res_ready) begin
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stop_mem[count_reg[IDX_W-1:0]] <= '{pos: req_pos, val: req_val};
        end
        rdata_reg <= stop_mem[idx_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        xf_reg       <= xf_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        d_reg        <= d_next;
        t_reg        <= t_next;
        dt_reg       <= dt_next;
        v0_sh_reg    <= v0_sh_next;
        v1_sh_reg    <= v1_sh_next;
        acc_reg      <= acc_next;
        bit_reg      <= bit_next;
        y_reg        <= y_next;
        pend_y_reg   <= pend_y_next;
        pend_seg_reg <= pend_seg_next;
    end

endmodule

>>> rtl/piecewise_linear_opacity_ramp.sv
// Top level of the piecewise-linear opacity ramp.
// The block holds up to MAX_STOPS opacity stops and evaluates a linear ramp
// over them. Clear and append requests complete in the idle state. An
// evaluate request scans the stops one at a time, each read passing through
// a wait and a load state; each segment whose span holds the query and is
// not empty then runs the eight-step shift-add multiplier that forms the
// numerator and the eight-step restoring divider that forms the rounded
// value, one bit per cycle each. A query yields one result per matching
// segment, with tlast on the final one, and none when no span holds it.
// Requests are taken one at a time; the result register lets the next
// request in while the final result still waits on m_tready.
module piecewise_linear_opacity_ramp #(
    parameter int MAX_STOPS = plor_pkg::MAX_STOPS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [16:0] stop_position, [24:17] stop_value, [32:25] query_x
    input  logic [plor_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] operation
    input  logic [plor_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] opacity, [13:8] segment_index
    output logic [plor_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                           m_tlast
);

    plor_pkg::div_req_t div_req;
    plor_pkg::div_rsp_t div_rsp;
    plor_pkg::res_t     res;
    logic               res_valid;
    logic               res_ready;

    logic                           m_tvalid_reg, m_tvalid_next;
    logic [plor_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                           m_tlast_reg, m_tlast_next;

    plor_ctrl #(
        .MAX_STOPS (MAX_STOPS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_op    (s_tuser[plor_pkg::OP_W-1:0]),
        .req_pos   (s_tdata[16:0]),
        .req_val   (s_tdata[24:17]),
        .req_x     (s_tdata[32:25]),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    plor_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        if (res_valid && res_ready) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = plor_pkg::M_TDATA_W'({res.segment_index, res.opacity});
            m_tlast_next  = res.last;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

>>> rtl/plor_chk.sv
// Port-level checker for the opacity ramp and its bind.
`include "piecewise_linear_opacity_ramp_defines.svh"

module plor_chk (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [plor_pkg::S_TUSER_W-1:0] s_tuser,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [plor_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tlast
);

    `PLOR_ASSERT_NEXT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
    `PLOR_ASSERT_NEXT(a_m_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
    `PLOR_ASSERT_SAME(a_busy_mid_query, aclk, aresetn, m_tvalid && !m_tlast, !s_tready, "request taken before query finished")
    `PLOR_ASSERT_NEXT(a_no_result_edit, aclk, aresetn, s_tvalid && s_tready && s_tuser != plor_pkg::OP_EVAL && !m_tvalid, !m_tvalid, "result from a non-evaluate request")

endmodule

bind piecewise_linear_opacity_ramp plor_chk u_plor_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
